// File: src/okps_pkg.sv
`default_nettype none

package okps_pkg;

  localparam int KEY_BITS_DEF  = 10;
  localparam int DATA_BITS_DEF = 32;
  localparam int MODE_W        = 3;

  // request modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PRED   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUCC   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd6;

  // memory port enables from the sequencer
  typedef struct packed {
    logic word_rd;
    logic word_wr;
    logic pay_rd;
    logic pay_wr;
  } store_ctl_t;

  // shared bit scan: bounded or full, highest or lowest
  typedef struct packed {
    logic use_bound;
    logic find_high;
  } scan_ctl_t;

endpackage

`default_nettype wire

// File: src/okps_scan.sv
`default_nettype none

module okps_scan #(
  parameter int WB = 5
) (
  input  logic [(1<<WB)-1:0] vec,
  input  logic [WB-1:0]      bound,
  input  okps_pkg::scan_ctl_t ctl,
  output logic               hit,
  output logic [WB-1:0]      pos
);
  import okps_pkg::*;

  localparam int VW = 1 << WB;

  logic [VW-1:0] masked;
  logic          in_range;

  always_comb begin
    masked   = '0;
    in_range = 1'b0;
    for (int i = 0; i < VW; i++) begin
      // strict bound: below for high scans, above for low scans
      in_range  = !ctl.use_bound ||
                  (ctl.find_high ? (WB'(i) < bound) : (WB'(i) > bound));
      masked[i] = vec[i] & in_range;
    end
    hit = |masked;
    pos = '0;
    if (ctl.find_high) begin
      for (int i = 0; i < VW; i++) begin
        if (masked[i]) pos = WB'(i);
      end
    end else begin
      for (int i = VW - 1; i >= 0; i--) begin
        if (masked[i]) pos = WB'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/okps_store.sv
`default_nettype none

module okps_store #(
  parameter int KEY_BITS  = okps_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = okps_pkg::DATA_BITS_DEF,
  parameter int WB        = (KEY_BITS + 1) / 2,
  parameter int SB        = KEY_BITS - WB
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  okps_pkg::store_ctl_t  ctl,
  input  logic [SB-1:0]         word_addr,
  input  logic [(1<<WB)-1:0]    word_wdata,
  input  logic [KEY_BITS-1:0]   key_addr,
  input  logic [DATA_BITS-1:0]  pay_wdata,
  output logic [(1<<WB)-1:0]    word_q,
  output logic [DATA_BITS-1:0]  pay_q,
  output logic [(1<<SB)-1:0]    summary
);
  import okps_pkg::*;

  localparam int VW = 1 << WB;
  localparam int NW = 1 << SB;
  localparam int NK = 1 << KEY_BITS;

  logic [VW-1:0]        pres_mem [NW];
  logic [DATA_BITS-1:0] pay_mem  [NK];
  logic [NW-1:0]        summary_r;
  logic [VW-1:0]        word_rd_r;
  logic                 word_vld_r;
  logic [DATA_BITS-1:0] pay_rd_r;

  // summary bit doubles as word valid, so the word memory needs no clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
    end else if (ctl.word_wr) begin
      summary_r[word_addr] <= |word_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.word_wr) begin
      pres_mem[word_addr] <= word_wdata;
    end
    if (ctl.word_rd) begin
      word_rd_r  <= pres_mem[word_addr];
      word_vld_r <= summary_r[word_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pay_wr) begin
      pay_mem[key_addr] <= pay_wdata;
    end
    if (ctl.pay_rd) begin
      pay_rd_r <= pay_mem[key_addr];
    end
  end

  assign word_q  = word_rd_r & {VW{word_vld_r}};
  assign pay_q   = pay_rd_r;
  assign summary = summary_r;

endmodule

`default_nettype wire

// File: src/ordered_key_set_pred_succ_top.sv
// sequence: insert, delete, lookup and unused modes read the key's word, then hand the result on;
// predecessor and successor scan the key's own word and, on a hit, read the payload; else
// summary scan, second word read, payload read, or a miss when no word that way holds a key;
// minimum and maximum always go through the summary, with a miss on an empty set
// throughput: one request at a time, taken only in idle; a stalled result holds the next back
// reset: synchronous active-low rst_n empties the set at once (summary flops cleared)
`default_nettype none

module ordered_key_set_pred_succ_top #(
  parameter int KEY_BITS  = okps_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = okps_pkg::DATA_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // request: mode, key, data from bit 0 up
  input  logic                                                in_tvalid,
  output logic                                                in_tready,
  input  logic [((okps_pkg::MODE_W+KEY_BITS+DATA_BITS+7)/8)*8-1:0] in_tdata,
  // result: found, result_key, result_data from bit 0 up
  output logic                                                out_tvalid,
  input  logic                                                out_tready,
  output logic [((1+KEY_BITS+DATA_BITS+7)/8)*8-1:0]           out_tdata
);
  import okps_pkg::*;

  localparam int WB    = (KEY_BITS + 1) / 2;   // bits per presence word index
  localparam int SB    = KEY_BITS - WB;        // summary index bits
  localparam int VW    = 1 << WB;
  localparam int NW    = 1 << SB;
  localparam int OUT_W = ((1 + KEY_BITS + DATA_BITS + 7) / 8) * 8;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;  // own word back, scan it or update it
  localparam logic [2:0] ST_SUM  = 3'd2;  // scan summary for another word
  localparam logic [2:0] ST_W2   = 3'd3;  // scan the neighbor word
  localparam logic [2:0] ST_PAY  = 3'd4;  // payload of the found key back
  localparam logic [2:0] ST_DONE = 3'd5;  // hand result to output register

  logic [2:0]           state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] data_r;
  logic [SB-1:0]        widx_r, widx_nxt;
  logic [KEY_BITS-1:0]  pos_r, pos_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [DATA_BITS-1:0] res_data_r, res_data_nxt;
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                 out_load;

  // request fields
  logic [MODE_W-1:0]    in_mode;
  logic [KEY_BITS-1:0]  in_key;
  logic [DATA_BITS-1:0] in_data;
  logic                 in_acc;

  // store interface
  store_ctl_t           st_ctl;
  logic [SB-1:0]        word_addr;
  logic [VW-1:0]        word_wdata;
  logic [KEY_BITS-1:0]  key_addr;
  logic [VW-1:0]        word_q;
  logic [DATA_BITS-1:0] pay_q;
  logic [NW-1:0]        summary;

  // shared scan unit
  logic [VW-1:0]        scan_vec;
  logic [WB-1:0]        scan_bound;
  scan_ctl_t            scan_ctl;
  logic                 scan_hit;
  logic [WB-1:0]        scan_pos;

  logic [SB-1:0]        idx;
  logic [WB-1:0]        lo;
  logic [VW-1:0]        onehot;
  logic                 bit_hit;
  logic                 is_search;
  logic [VW-1:0]        sum_ext;

  assign in_mode = in_tdata[MODE_W-1:0];
  assign in_key  = in_tdata[MODE_W +: KEY_BITS];
  assign in_data = in_tdata[MODE_W+KEY_BITS +: DATA_BITS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign idx     = key_r[KEY_BITS-1:WB];
  assign lo      = key_r[WB-1:0];
  assign onehot  = {{(VW-1){1'b0}}, 1'b1} << lo;
  assign bit_hit = word_q[lo];
  assign is_search = (mode_r == MODE_PRED) || (mode_r == MODE_SUCC);

  okps_store #(
    .KEY_BITS (KEY_BITS),
    .DATA_BITS(DATA_BITS),
    .WB       (WB),
    .SB       (SB)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (st_ctl),
    .word_addr (word_addr),
    .word_wdata(word_wdata),
    .key_addr  (key_addr),
    .pay_wdata (data_r),
    .word_q    (word_q),
    .pay_q     (pay_q),
    .summary   (summary)
  );

  okps_scan #(
    .WB(WB)
  ) u_scan (
    .vec  (scan_vec),
    .bound(scan_bound),
    .ctl  (scan_ctl),
    .hit  (scan_hit),
    .pos  (scan_pos)
  );

  // scan operand select: own word, summary, or neighbor word
  always_comb begin
    sum_ext            = '0;
    sum_ext[NW-1:0]    = summary;
    scan_bound         = '0;
    scan_ctl.find_high = (mode_r == MODE_PRED) || (mode_r == MODE_MAX);
    scan_ctl.use_bound = 1'b0;
    scan_vec           = word_q;
    case (state_r)
      ST_CHK: begin
        // min and max skip the own word and go straight to the summary
        scan_vec           = is_search ? word_q : '0;
        scan_bound         = lo;
        scan_ctl.use_bound = 1'b1;
      end
      ST_SUM: begin
        scan_vec               = sum_ext;
        scan_bound[SB-1:0]     = idx;
        scan_ctl.use_bound     = is_search;
      end
      default: begin
        scan_vec = word_q;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    st_ctl        = '0;
    word_addr     = in_key[KEY_BITS-1:WB];
    word_wdata    = word_q;
    key_addr      = in_key;
    widx_nxt      = widx_r;
    pos_nxt       = pos_r;
    res_found_nxt = res_found_r;
    res_key_nxt   = res_key_r;
    res_data_nxt  = res_data_r;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          st_ctl.word_rd = 1'b1;
          st_ctl.pay_rd  = 1'b1;
          state_nxt      = ST_CHK;
        end
      end
      ST_CHK: begin
        word_addr = idx;
        key_addr  = key_r;
        case (mode_r)
          MODE_INSERT, MODE_DELETE: begin
            word_wdata     = (mode_r == MODE_INSERT) ? (word_q | onehot) : (word_q & ~onehot);
            st_ctl.word_wr = 1'b1;
            st_ctl.pay_wr  = (mode_r == MODE_INSERT);
            res_found_nxt  = bit_hit;
            res_key_nxt    = key_r;
            res_data_nxt   = bit_hit ? pay_q : '0;
            state_nxt      = ST_DONE;
          end
          MODE_LOOKUP: begin
            res_found_nxt = bit_hit;
            res_key_nxt   = bit_hit ? key_r : '0;
            res_data_nxt  = bit_hit ? pay_q : '0;
            state_nxt     = ST_DONE;
          end
          MODE_PRED, MODE_SUCC, MODE_MIN, MODE_MAX: begin
            if (scan_hit) begin
              key_addr      = {idx, scan_pos};
              st_ctl.pay_rd = 1'b1;
              pos_nxt       = {idx, scan_pos};
              state_nxt     = ST_PAY;
            end else begin
              state_nxt = ST_SUM;
            end
          end
          default: begin
            res_found_nxt = 1'b0;
            res_key_nxt   = '0;
            res_data_nxt  = '0;
            state_nxt     = ST_DONE;
          end
        endcase
      end
      ST_SUM: begin
        word_addr = scan_pos[SB-1:0];
        if (scan_hit) begin
          st_ctl.word_rd = 1'b1;
          widx_nxt       = scan_pos[SB-1:0];
          state_nxt      = ST_W2;
        end else begin
          // no neighbor word holds a key
          res_found_nxt = 1'b0;
          res_key_nxt   = '0;
          res_data_nxt  = '0;
          state_nxt     = ST_DONE;
        end
      end
      ST_W2: begin
        // summary bit was set, so this word is nonzero and the scan hits
        key_addr      = {widx_r, scan_pos};
        st_ctl.pay_rd = 1'b1;
        pos_nxt       = {widx_r, scan_pos};
        state_nxt     = ST_PAY;
      end
      ST_PAY: begin
        res_found_nxt = 1'b1;
        res_key_nxt   = pos_r;
        res_data_nxt  = pay_q;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tdata_nxt                             = '0;
    out_tdata_nxt[0]                          = res_found_r;
    out_tdata_nxt[1 +: KEY_BITS]              = res_key_r;
    out_tdata_nxt[1+KEY_BITS +: DATA_BITS]    = res_data_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      data_r <= in_data;
    end
    widx_r      <= widx_nxt;
    pos_r       <= pos_nxt;
    res_found_r <= res_found_nxt;
    res_key_r   <= res_key_nxt;
    res_data_r  <= res_data_nxt;
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// File: src/okps_checker.sv
`default_nettype none

module okps_checker #(
  parameter int KEY_BITS  = okps_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = okps_pkg::DATA_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic [((okps_pkg::MODE_W+KEY_BITS+DATA_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [((1+KEY_BITS+DATA_BITS+7)/8)*8-1:0] out_tdata
);
  import okps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // after a request the block stays busy in the check state and the state that follows it
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("request taken while busy");

  // a new result only appears after a busy cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without request");

  // not found means no data word
  a_miss_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[1+KEY_BITS +: DATA_BITS] == '0)
    else $error("data on a miss");

endmodule

bind ordered_key_set_pred_succ_top okps_checker #(
  .KEY_BITS (KEY_BITS),
  .DATA_BITS(DATA_BITS)
) u_okps_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import okps_pkg::*;

  localparam int KEY_W    = KEY_BITS_DEF;
  localparam int DATA_W   = DATA_BITS_DEF;
  localparam int NKEYS    = 1 << KEY_W;
  localparam int IN_W     = ((MODE_W + KEY_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W    = ((1 + KEY_W + DATA_W + 7) / 8) * 8;
  localparam int N_RANDOM = 1300;
  localparam int SEG_LEN  = 100;
  localparam int HOLD_CYC = 200;
  localparam int HOLD_AT  = 450;
  localparam int DIR_N    = 24;

  // mode 7 is not decoded by the block and must come back as a miss
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // request fields, mode in the low bits
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic [MODE_W-1:0] mode;
  } set_req_t;

  // result fields, found in bit 0
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [KEY_W-1:0]  key;
    logic              found;
  } set_result_t;

  // directed row: request, then an optional hand-written answer
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    bit                typed;
    logic              found;
    logic [KEY_W-1:0]  rkey;
    logic [DATA_W-1:0] rdata;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // shadow copy of the key set
  bit                key_present [NKEYS];
  logic [DATA_W-1:0] key_payload [NKEYS];

  set_result_t expected_results [$];
  int unsigned mismatch_cnt;
  bit          hold_go;
  bit          hold_done;
  bit          no_idle;
  set_result_t mon_got;
  set_result_t mon_want;

  // directed requests: empty-set searches, extremes, replace, double delete, unused mode
  dir_row_t dir_tab [DIR_N] = '{
    '{MODE_MIN,    10'd0,    32'h0,        1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_MAX,    10'd0,    32'h0,        1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_PRED,   10'd1023, 32'h0,        1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_SUCC,   10'd0,    32'h0,        1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_LOOKUP, 10'd0,    32'h0,        1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_DELETE, 10'd5,    32'h0,        1'b1, 1'b0, 10'd5,    32'h0},
    '{MODE_UNUSED, 10'd1023, 32'hffffffff, 1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_INSERT, 10'd0,    32'hffffffff, 1'b1, 1'b0, 10'd0,    32'h0},
    '{MODE_INSERT, 10'd1023, 32'h0,        1'b1, 1'b0, 10'd1023, 32'h0},
    '{MODE_INSERT, 10'd512,  32'ha5a5a5a5, 1'b1, 1'b0, 10'd512,  32'h0},
    '{MODE_PRED,   10'd0,    32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_SUCC,   10'd1023, 32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_PRED,   10'd1023, 32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_SUCC,   10'd0,    32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_MIN,    10'd0,    32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_MAX,    10'd0,    32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_LOOKUP, 10'd1023, 32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_INSERT, 10'd0,    32'h12345678, 1'b1, 1'b1, 10'd0,    32'hffffffff},
    '{MODE_DELETE, 10'd512,  32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_DELETE, 10'd512,  32'h0,        1'b1, 1'b0, 10'd512,  32'h0},
    '{MODE_SUCC,   10'd1,    32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_PRED,   10'd1022, 32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_LOOKUP, 10'd512,  32'h0,        1'b0, 1'b0, 10'd0,    32'h0},
    '{MODE_UNUSED, 10'd0,    32'h5a5a5a5a, 1'b1, 1'b0, 10'd0,    32'h0}
  };

  ordered_key_set_pred_succ_top #(
    .KEY_BITS  (KEY_W),
    .DATA_BITS (DATA_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // apply one request to the shadow set and return what the block should answer
  function automatic set_result_t apply_request(set_req_t r);
    set_result_t res;
    int          i;
    res = '0;
    case (r.mode)
      MODE_INSERT, MODE_DELETE: begin
        res.found = key_present[r.key];
        res.key   = r.key;
        if (key_present[r.key]) begin
          res.data = key_payload[r.key];
        end
        // insert overwrites the payload, delete only drops presence
        if (r.mode == MODE_INSERT) begin
          key_present[r.key] = 1'b1;
          key_payload[r.key] = r.data;
        end else begin
          key_present[r.key] = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        if (key_present[r.key]) begin
          res = '{data: key_payload[r.key], key: r.key, found: 1'b1};
        end
      end
      MODE_PRED, MODE_MAX: begin
        // strict predecessor scans down from key-1, maximum from the top
        i = (r.mode == MODE_MAX) ? NKEYS - 1 : int'(r.key) - 1;
        for (; i >= 0 && !res.found; i--) begin
          if (key_present[i]) begin
            res = '{data: key_payload[i], key: KEY_W'(i), found: 1'b1};
          end
        end
      end
      MODE_SUCC, MODE_MIN: begin
        // strict successor scans up from key+1, minimum from zero
        i = (r.mode == MODE_MIN) ? 0 : int'(r.key) + 1;
        for (; i < NKEYS && !res.found; i++) begin
          if (key_present[i]) begin
            res = '{data: key_payload[i], key: KEY_W'(i), found: 1'b1};
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  // half back to back, some short pauses, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // offer one request after a gap; valid stays high across back-to-back requests
  task automatic send_req(set_req_t r, bit typed, set_result_t typed_res);
    int unsigned gap;
    set_result_t pred;
    gap = (no_idle || (hold_go && !hold_done)) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata[$bits(set_req_t)-1:0] = r;
    in_tvalid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_tready);
    // request taken at this edge: update the shadow set in order
    pred = apply_request(r);
    expected_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // request source: directed table first, then random segments
  initial begin
    set_req_t    req;
    set_result_t typed_res;
    int unsigned r;
    int unsigned ins_w;
    int unsigned del_w;
    int unsigned lo_k;
    int unsigned hi_k;
    int unsigned span;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    hold_go    = 1'b0;
    no_idle    = 1'b0;
    mismatch_cnt = 0;
    for (int k = 0; k < NKEYS; k++) begin
      key_payload[k] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int n = 0; n < DIR_N; n++) begin
      req       = '{data: dir_tab[n].data, key: dir_tab[n].key, mode: dir_tab[n].mode};
      typed_res = '{data: dir_tab[n].rdata, key: dir_tab[n].rkey, found: dir_tab[n].found};
      send_req(req, dir_tab[n].typed, typed_res);
    end

    ins_w = 40;
    del_w = 10;
    lo_k  = 0;
    hi_k  = NKEYS - 1;
    for (int n = 0; n < N_RANDOM; n++) begin
      // each segment picks a key window and a grow or shrink bias
      if (n % SEG_LEN == 0) begin
        r = $urandom_range(0, 3);
        span = (r == 0) ? NKEYS : (r == 3) ? 64 : 32;
        case (r)
          0: lo_k = 0;
          1: lo_k = 0;
          2: lo_k = NKEYS - span;
          default: lo_k = $urandom_range(0, NKEYS - span);
        endcase
        hi_k = lo_k + span - 1;
        if ((n / SEG_LEN) % 3 == 2) begin
          ins_w = 12;
          del_w = 45;
        end else begin
          ins_w = $urandom_range(30, 50);
          del_w = $urandom_range(5, 20);
        end
        no_idle = ((n / SEG_LEN) % 4 == 2);
      end
      // long receiver hold-off, sender keeps pushing meanwhile
      if (n == HOLD_AT) begin
        no_idle = 1'b0;
        hold_go = 1'b1;
      end

      r = $urandom_range(0, 99);
      if (r < ins_w) begin
        req.mode = MODE_INSERT;
      end else if (r < ins_w + del_w) begin
        req.mode = MODE_DELETE;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 20)      req.mode = MODE_LOOKUP;
        else if (r < 45) req.mode = MODE_PRED;
        else if (r < 70) req.mode = MODE_SUCC;
        else if (r < 84) req.mode = MODE_MIN;
        else if (r < 98) req.mode = MODE_MAX;
        else             req.mode = MODE_UNUSED;
      end

      r = $urandom_range(0, 99);
      if (r < 3)       req.key = '0;
      else if (r < 6)  req.key = '1;
      else if (r < 20) req.key = KEY_W'($urandom_range(0, NKEYS - 1));
      else             req.key = KEY_W'($urandom_range(lo_k, hi_k));

      r = $urandom_range(0, 99);
      if (r < 5)       req.data = '0;
      else if (r < 10) req.data = '1;
      else             req.data = DATA_W'($urandom);

      send_req(req, 1'b0, '0);
    end
    in_tvalid = 1'b0;
    no_idle   = 1'b1;

    // drain outstanding results, then wait on for stray outputs
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result sink: random stalls, one long hold-off counted here
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        stall = no_idle ? 0 : pick_gap();
        if (stall > 0) begin
          out_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // result checker: every accepted result against the oldest pending prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mon_got = set_result_t'(out_tdata[$bits(set_result_t)-1:0]);
      if (expected_results.size() == 0) begin
        report_mismatch("result with no pending request", '0, mon_got.data);
      end else begin
        mon_want = expected_results.pop_front();
        if (mon_got.found !== mon_want.found) begin
          report_mismatch("found", DATA_W'(mon_want.found), DATA_W'(mon_got.found));
        end
        if (mon_got.key !== mon_want.key) begin
          report_mismatch("result_key", DATA_W'(mon_want.key), DATA_W'(mon_got.key));
        end
        if (mon_got.data !== mon_want.data) begin
          report_mismatch("result_data", mon_want.data, mon_got.data);
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
src/okps_pkg.sv
src/okps_scan.sv
src/okps_store.sv
src/ordered_key_set_pred_succ_top.sv
src/okps_checker.sv
tb/tb.sv
